@@ rtl/core/spto_pkg.sv @@
// Shared types and constants for the sine period table oscillator.
// Holds widths, register indexes, the arctangent table and the control interface.
// No dependencies.
package spto_pkg;

    localparam int SR_W     = 18;
    localparam int FREQ_W   = 26;
    localparam int AMP_W    = 16;
    localparam int POS_W    = 18;
    localparam int CFG_W    = 26;
    localparam int IDX_W    = 2;
    localparam int DIV_W    = 44;
    localparam int DVS_W    = 26;
    localparam int CNT_W    = 6;
    localparam int FRAC_STEPS = 32;
    localparam int MUL_A_W  = 33;
    localparam int MUL_B_W  = 27;
    localparam int PROD_W   = 60;
    localparam int CRD_W    = 34;
    localparam int ATAN_LEN = 24;
    localparam int ITER_W   = 5;
    localparam int ITER_DEFAULT = 16;

    localparam logic [POS_W-1:0]  MAX18      = 18'h3FFFF;
    localparam logic [SR_W-1:0]   SR_RESET   = 18'd44100;
    localparam logic [FREQ_W-1:0] FREQ_RESET = 26'd112640;
    localparam logic [AMP_W-1:0]  AMP_RESET  = 16'd4096;
    localparam logic signed [CRD_W-1:0] CORDIC_K = 34'sd652032874;

    localparam logic [IDX_W-1:0] REG_SAMPLE_RATE = 2'd0;
    localparam logic [IDX_W-1:0] REG_FREQUENCY   = 2'd1;
    localparam logic [IDX_W-1:0] REG_AMPLITUDE   = 2'd2;

    // arctangent of 2^-i in units of 2^-32 turn
    function automatic logic [29:0] atan_turn(input logic [ITER_W-1:0] i);
        logic [29:0] r;
        case (i)
            5'd0:  r = 30'd536870912;
            5'd1:  r = 30'd316933406;
            5'd2:  r = 30'd167458907;
            5'd3:  r = 30'd85005780;
            5'd4:  r = 30'd42667331;
            5'd5:  r = 30'd21354465;
            5'd6:  r = 30'd10679838;
            5'd7:  r = 30'd5340245;
            5'd8:  r = 30'd2670163;
            5'd9:  r = 30'd1335087;
            5'd10: r = 30'd667544;
            5'd11: r = 30'd333772;
            5'd12: r = 30'd166886;
            5'd13: r = 30'd83443;
            5'd14: r = 30'd41722;
            5'd15: r = 30'd20861;
            5'd16: r = 30'd10430;
            5'd17: r = 30'd5215;
            5'd18: r = 30'd2608;
            5'd19: r = 30'd1304;
            5'd20: r = 30'd652;
            5'd21: r = 30'd326;
            5'd22: r = 30'd163;
            5'd23: r = 30'd81;
            default: r = 30'd0;
        endcase
        return r;
    endfunction

    typedef struct packed {
        logic len_div;
        logic len_load;
        logic rs_mul;
        logic rs_div;
        logic rs_load;
        logic pl_store;
        logic pos_clear;
        logic pos_wrap;
        logic ph_mul;
        logic mod_div;
        logic frac_div;
        logic cordic_go;
        logic amp_mul;
        logic out_load;
        logic pos_inc;
    } cmd_t;

    typedef struct packed {
        logic div_done;
        logic cordic_done;
        logic len_ne;
        logic pl_zero;
        logic out_free;
    } status_t;

    typedef enum logic [11:0] {
        S_IDLE = 12'b0000_0000_0001,
        S_LEN  = 12'b0000_0000_0010,
        S_LCHK = 12'b0000_0000_0100,
        S_RMUL = 12'b0000_0000_1000,
        S_RDIV = 12'b0000_0001_0000,
        S_CHK  = 12'b0000_0010_0000,
        S_PMUL = 12'b0000_0100_0000,
        S_MST  = 12'b0000_1000_0000,
        S_MOD  = 12'b0001_0000_0000,
        S_FRAC = 12'b0010_0000_0000,
        S_CORD = 12'b0100_0000_0000,
        S_OUT  = 12'b1000_0000_0000
    } state_t;

endpackage

@@ rtl/core/sine_period_table_oscillator_top.sv @@
// Channel    Dir  Payload
// s_axis     in   tdata[0] tick (request one sample), bits 7:1 zero
// m_axis     out  tdata[15:0] sample, signed Q4.12
// cfg        in   cfg_addr 0 sample_rate, 1 frequency, 2 amplitude
// A tick runs two divisions and a fraction step on the single shared divider, then the
// CORDIC; a period length change adds a rescale division.
// A tick with no period ends after the period update. Reset is asynchronous, active low.
// The next tick is taken while a finished sample waits in the output register.
// Top level of the sine oscillator; uses spto_pkg, spto_ctrl, spto_dp.
module sine_period_table_oscillator_top
#(
    parameter int SINE_ITERATIONS = spto_pkg::ITER_DEFAULT
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [7:0]                     s_axis_tdata,   // [0] tick
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [spto_pkg::AMP_W-1:0]     m_axis_tdata,   // [15:0] sample
    input  logic                           cfg_we,
    input  logic [spto_pkg::IDX_W-1:0]     cfg_addr,
    input  logic [spto_pkg::CFG_W-1:0]     cfg_wdata
);

    spto_pkg::cmd_t    cmd;
    spto_pkg::status_t status;

    spto_ctrl u_ctrl
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .tick          (s_axis_tdata[0]),
        .status        (status),
        .cmd           (cmd)
    );

    spto_dp #(.SINE_ITERATIONS(SINE_ITERATIONS)) u_dp
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata),
        .cmd           (cmd),
        .status        (status),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

endmodule

@@ rtl/core/spto_div.sv @@
// Radix-2 restoring divider, one quotient bit per cycle.
// Fraction mode keeps the last remainder and runs 32 more steps on zeros.
// Uses spto_pkg.
module spto_div
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic                           frac,
    input  logic [spto_pkg::DIV_W-1:0]     dividend,
    input  logic [spto_pkg::DVS_W-1:0]     divisor,
    output logic [spto_pkg::DIV_W-1:0]     quot,
    output logic                           busy,
    output logic                           done
);

    logic [spto_pkg::DIV_W-1:0] dq_reg, dq_next;
    logic [spto_pkg::DVS_W-1:0] rem_reg, rem_next;
    logic [spto_pkg::DVS_W-1:0] dvs_reg;
    logic [spto_pkg::CNT_W-1:0] cnt_reg, cnt_next;
    logic                       busy_reg, busy_next;
    logic                       done_reg, done_next;
    logic [spto_pkg::DVS_W:0]   shifted;
    logic                       fits;

    assign shifted = {rem_reg, dq_reg[spto_pkg::DIV_W-1]};
    assign fits    = shifted >= {1'b0, dvs_reg};

    always_comb
    begin
        dq_next   = dq_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            busy_next = 1'b1;
            if (frac)
            begin
                dq_next  = '0;
                cnt_next = spto_pkg::CNT_W'(spto_pkg::FRAC_STEPS - 1);
            end
            else
            begin
                dq_next  = dividend;
                rem_next = '0;
                cnt_next = spto_pkg::CNT_W'(spto_pkg::DIV_W - 1);
            end
        end
        else if (busy_reg)
        begin
            dq_next  = {dq_reg[spto_pkg::DIV_W-2:0], fits};
            rem_next = fits ? spto_pkg::DVS_W'(shifted - {1'b0, dvs_reg})
                            : shifted[spto_pkg::DVS_W-1:0];
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dq_reg  <= dq_next;
        rem_reg <= rem_next;
        if (start && !frac)
            dvs_reg <= divisor;
    end

    assign quot = dq_reg;
    assign busy = busy_reg;
    assign done = done_reg;

endmodule

@@ rtl/core/spto_cordic.sv @@
// Iterative rotation-mode CORDIC, one micro-rotation per cycle.
// Folds a 32 bit turn into the right half plane and returns y in Q1.30.
// Uses spto_pkg.
module spto_cordic
#(
    parameter int SINE_ITERATIONS = spto_pkg::ITER_DEFAULT
)
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    input  logic [31:0]                          turn,
    output logic signed [spto_pkg::CRD_W-1:0]    y,
    output logic                                 done
);

    localparam int NEFF = (SINE_ITERATIONS > spto_pkg::ATAN_LEN) ?
                          spto_pkg::ATAN_LEN : SINE_ITERATIONS;

    logic signed [spto_pkg::CRD_W-1:0] x_reg, x_next;
    logic signed [spto_pkg::CRD_W-1:0] y_reg, y_next;
    logic signed [spto_pkg::CRD_W-1:0] z_reg, z_next;
    logic [spto_pkg::ITER_W-1:0]       i_reg, i_next;
    logic                              busy_reg, busy_next;
    logic                              done_reg, done_next;
    logic [31:0]                       t_fold;
    logic [31:0]                       t_test;
    logic signed [spto_pkg::CRD_W-1:0] dx, dy, ang;

    assign t_test = turn + 32'h4000_0000;
    assign t_fold = t_test[31] ? (32'h8000_0000 - turn) : turn;
    assign dx     = y_reg >>> i_reg;
    assign dy     = x_reg >>> i_reg;
    assign ang    = signed'({4'b0, spto_pkg::atan_turn(i_reg)});

    always_comb
    begin
        x_next    = x_reg;
        y_next    = y_reg;
        z_next    = z_reg;
        i_next    = i_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            x_next    = spto_pkg::CORDIC_K;
            y_next    = '0;
            z_next    = signed'({{2{t_fold[31]}}, t_fold});
            i_next    = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!z_reg[spto_pkg::CRD_W-1])
            begin
                x_next = x_reg - dx;
                y_next = y_reg + dy;
                z_next = z_reg - ang;
            end
            else
            begin
                x_next = x_reg + dx;
                y_next = y_reg - dy;
                z_next = z_reg + ang;
            end
            i_next = i_reg + 1'b1;
            if (i_reg == spto_pkg::ITER_W'(NEFF - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            i_reg    <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            i_reg    <= i_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg <= x_next;
        y_reg <= y_next;
        z_reg <= z_next;
    end

    assign y    = y_reg;
    assign done = done_reg;

endmodule

@@ rtl/core/spto_dp.sv @@
// Datapath: configuration, position and period registers, shared multiplier,
// divider and CORDIC, and the output register. Uses spto_pkg, spto_div, spto_cordic.
module spto_dp
#(
    parameter int SINE_ITERATIONS = spto_pkg::ITER_DEFAULT
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [spto_pkg::IDX_W-1:0]        cfg_addr,
    input  logic [spto_pkg::CFG_W-1:0]        cfg_wdata,
    input  spto_pkg::cmd_t                    cmd,
    output spto_pkg::status_t                 status,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [spto_pkg::AMP_W-1:0]        m_axis_tdata
);

    logic [spto_pkg::SR_W-1:0]   sr_reg;
    logic [spto_pkg::FREQ_W-1:0] freq_reg;
    logic [spto_pkg::AMP_W-1:0]  amp_reg;
    logic [spto_pkg::POS_W-1:0]  pos_reg, pos_next;
    logic [spto_pkg::POS_W-1:0]  pl_reg;
    logic [spto_pkg::POS_W-1:0]  len_reg;
    logic signed [spto_pkg::PROD_W-1:0] prod_reg;
    logic [spto_pkg::AMP_W-1:0]  sample_reg;
    logic                        out_valid_reg;

    logic signed [spto_pkg::MUL_A_W-1:0] mul_a;
    logic signed [spto_pkg::MUL_B_W-1:0] mul_b;
    logic [spto_pkg::DVS_W-1:0]  denom;
    logic [37:0]                 rs_num;
    logic                        div_start;
    logic [spto_pkg::DIV_W-1:0]  div_dividend;
    logic [spto_pkg::DVS_W-1:0]  div_divisor;
    logic [spto_pkg::DIV_W-1:0]  quot;
    logic                        div_busy;
    logic                        div_done;
    logic [spto_pkg::POS_W-1:0]  quot_sat;
    logic signed [spto_pkg::CRD_W-1:0] cordic_y;
    logic                        cordic_done;
    logic signed [spto_pkg::PROD_W-1:0] rounded;
    logic signed [29:0]          scaled;
    logic [spto_pkg::AMP_W-1:0]  sat_sample;

    assign denom  = {sr_reg, 8'b0};
    assign rs_num = {prod_reg[35:0], 1'b0} + {20'b0, pl_reg};
    assign quot_sat = (|quot[spto_pkg::DIV_W-1:spto_pkg::POS_W]) ? spto_pkg::MAX18
                                                                : quot[spto_pkg::POS_W-1:0];

    // divider operand selection
    always_comb
    begin
        div_start    = cmd.len_div | cmd.rs_div | cmd.mod_div | cmd.frac_div;
        div_dividend = {18'b0, denom};
        div_divisor  = freq_reg;
        if (cmd.rs_div)
        begin
            div_dividend = {6'b0, rs_num};
            div_divisor  = {7'b0, pl_reg, 1'b0};
        end
        else if (cmd.mod_div)
        begin
            div_dividend = prod_reg[spto_pkg::DIV_W-1:0];
            div_divisor  = denom;
        end
    end

    spto_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .frac     (cmd.frac_div),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .quot     (quot),
        .busy     (div_busy),
        .done     (div_done)
    );

    spto_cordic #(.SINE_ITERATIONS(SINE_ITERATIONS)) u_cordic
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.cordic_go),
        .turn  (quot[31:0]),
        .y     (cordic_y),
        .done  (cordic_done)
    );

    // shared multiplier operand selection
    always_comb
    begin
        mul_a = signed'({15'b0, pos_reg});
        mul_b = signed'({9'b0, len_reg});
        if (cmd.ph_mul)
            mul_b = signed'({1'b0, freq_reg});
        else if (cmd.amp_mul)
        begin
            mul_a = cordic_y[spto_pkg::MUL_A_W-1:0];
            mul_b = signed'({{(spto_pkg::MUL_B_W-spto_pkg::AMP_W){amp_reg[15]}}, amp_reg});
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.rs_mul || cmd.ph_mul || cmd.amp_mul)
            prod_reg <= spto_pkg::PROD_W'(mul_a * mul_b);
    end

    // round to nearest, then clamp to Q4.12
    assign rounded = prod_reg + (spto_pkg::PROD_W'(1) <<< 29);
    assign scaled  = rounded[59:30];
    always_comb
    begin
        if (scaled > 30'sd32767)
            sat_sample = 16'h7FFF;
        else if (scaled < -30'sd32768)
            sat_sample = 16'h8000;
        else
            sat_sample = scaled[15:0];
    end

    always_comb
    begin
        pos_next = pos_reg;
        if (cmd.pos_clear)
            pos_next = '0;
        else if (cmd.rs_load)
            pos_next = quot_sat;
        else if (cmd.pos_wrap && (pos_reg >= pl_reg))
            pos_next = '0;
        else if (cmd.pos_inc)
            pos_next = pos_reg + 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sr_reg        <= spto_pkg::SR_RESET;
            freq_reg      <= spto_pkg::FREQ_RESET;
            amp_reg       <= spto_pkg::AMP_RESET;
            pos_reg       <= '0;
            pl_reg        <= '0;
            len_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_addr)
                    spto_pkg::REG_SAMPLE_RATE: sr_reg   <= cfg_wdata[spto_pkg::SR_W-1:0];
                    spto_pkg::REG_FREQUENCY:   freq_reg <= cfg_wdata;
                    spto_pkg::REG_AMPLITUDE:   amp_reg  <= cfg_wdata[spto_pkg::AMP_W-1:0];
                    default: ;
                endcase
            end
            pos_reg <= pos_next;
            if (cmd.len_load)
                len_reg <= (freq_reg == '0) ? '0 : quot_sat;
            if (cmd.pl_store)
                pl_reg <= len_reg;
            if (cmd.out_load)
                out_valid_reg <= 1'b1;
            else if (m_axis_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
            sample_reg <= sat_sample;
    end

    assign status.div_done    = div_done;
    assign status.cordic_done = cordic_done;
    assign status.len_ne      = len_reg != pl_reg;
    assign status.pl_zero     = pl_reg == '0;
    assign status.out_free    = !out_valid_reg || m_axis_tready;

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = sample_reg;

    // a new division never starts on top of a running one
    a_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> !div_busy)
        else $error("divider restarted while busy");

    // after a sample the position is at most one period
    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |=> (pos_reg <= pl_reg) && (pl_reg != '0))
        else $error("position beyond period after sample");

    // the output register is never overwritten while full and stalled
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!out_valid_reg || m_axis_tready))
        else $error("output overwritten while stalled");

endmodule

@@ rtl/core/spto_ctrl.sv @@
// Control state machine: sequences period update, rescale, phase, sine and output.
// Uses spto_pkg.
module spto_ctrl
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic                 tick,
    input  spto_pkg::status_t    status,
    output spto_pkg::cmd_t       cmd
);

    spto_pkg::state_t state_reg, state_next;

    assign s_axis_tready = state_reg == spto_pkg::S_IDLE;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            spto_pkg::S_IDLE:
            begin
                if (s_axis_tvalid && tick)
                begin
                    cmd.len_div = 1'b1;
                    state_next  = spto_pkg::S_LEN;
                end
            end
            spto_pkg::S_LEN:
            begin
                if (status.div_done)
                begin
                    cmd.len_load = 1'b1;
                    state_next   = spto_pkg::S_LCHK;
                end
            end
            spto_pkg::S_LCHK:
            begin
                if (!status.len_ne)
                    state_next = spto_pkg::S_CHK;
                else if (status.pl_zero)
                begin
                    cmd.pos_clear = 1'b1;
                    cmd.pl_store  = 1'b1;
                    state_next    = spto_pkg::S_CHK;
                end
                else
                begin
                    cmd.rs_mul = 1'b1;
                    state_next = spto_pkg::S_RMUL;
                end
            end
            spto_pkg::S_RMUL:
            begin
                cmd.rs_div = 1'b1;
                state_next = spto_pkg::S_RDIV;
            end
            spto_pkg::S_RDIV:
            begin
                if (status.div_done)
                begin
                    cmd.rs_load  = 1'b1;
                    cmd.pl_store = 1'b1;
                    state_next   = spto_pkg::S_CHK;
                end
            end
            spto_pkg::S_CHK:
            begin
                // drop the tick when there is no period
                if (status.pl_zero)
                    state_next = spto_pkg::S_IDLE;
                else
                begin
                    cmd.pos_wrap = 1'b1;
                    state_next   = spto_pkg::S_PMUL;
                end
            end
            spto_pkg::S_PMUL:
            begin
                cmd.ph_mul = 1'b1;
                state_next = spto_pkg::S_MST;
            end
            spto_pkg::S_MST:
            begin
                cmd.mod_div = 1'b1;
                state_next  = spto_pkg::S_MOD;
            end
            spto_pkg::S_MOD:
            begin
                if (status.div_done)
                begin
                    cmd.frac_div = 1'b1;
                    state_next   = spto_pkg::S_FRAC;
                end
            end
            spto_pkg::S_FRAC:
            begin
                if (status.div_done)
                begin
                    cmd.cordic_go = 1'b1;
                    state_next    = spto_pkg::S_CORD;
                end
            end
            spto_pkg::S_CORD:
            begin
                if (status.cordic_done)
                begin
                    cmd.amp_mul = 1'b1;
                    state_next  = spto_pkg::S_OUT;
                end
            end
            spto_pkg::S_OUT:
            begin
                // hold until the output register can take the sample
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    cmd.pos_inc  = 1'b1;
                    state_next   = spto_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = spto_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= spto_pkg::S_IDLE;
        else
            state_reg <= state_next;
    end

    // divider results are only consumed in the states that wait for them
    a_done_wait: assert property (@(posedge clk) disable iff (!rst_n)
        status.div_done |-> (state_reg == spto_pkg::S_LEN || state_reg == spto_pkg::S_RDIV
                             || state_reg == spto_pkg::S_MOD || state_reg == spto_pkg::S_FRAC))
        else $error("divider finished outside a wait state");

    // an accepted tick leaves idle on the next cycle
    a_leave_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tready && s_axis_tvalid && tick) |=> (state_reg == spto_pkg::S_LEN))
        else $error("tick accepted without starting");

endmodule
